// ===== design/cda_pkg.sv =====
// Package for the calendar date counter: operation codes, sequencer states,
// field widths and the month-length and leap-year helpers.
// Used by calendar_date_advance; depends on nothing.
package cda_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int ADDF_W  = 12;  // width of the days_to_add field
  localparam int DACC_W  = 13;  // day accumulator: 31 + 4095 fits

  // Number of low days_to_add bits that take part in an add.
  localparam int ADD_WIDTH = 12;
  localparam logic [ADDF_W-1:0] ADD_MASK = ADDF_W'((17'd1 << ADD_WIDTH) - 17'd1);

  localparam logic [YEAR_W-1:0]  YEAR_LAST  = YEAR_W'(9999);
  localparam logic [MONTH_W-1:0] MONTH_LAST = MONTH_W'(12);

  // Divide by 100 as a reciprocal multiply: exact for every 14-bit year.
  localparam int                 DIV100_SHIFT = 19;
  localparam logic [12:0]        DIV100_MUL   = 13'd5243;
  localparam int                 PROD_W       = YEAR_W + 13;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_INC  = 2'd1,
    OP_ADD  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOP,
    ST_LEAP,
    ST_OUT
  } state_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      default:                                    len = leap ? 5'd29 : 5'd28;
    endcase
    return len;
  endfunction

  // Divisible by 400, or by 4 and not by 100.
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [PROD_W-1:0] prod;
    logic [7:0]        quo;
    logic [YEAR_W-1:0] rem;
    prod = PROD_W'(y) * PROD_W'(DIV100_MUL);
    quo  = 8'(prod >> DIV100_SHIFT);
    rem  = y - YEAR_W'(quo) * YEAR_W'(100);
    return (rem == '0) ? (quo[1:0] == 2'b00) : (y[1:0] == 2'b00);
  endfunction

endpackage

// ===== design/calendar_date_advance.sv =====
// Top level of the Gregorian date counter: date registers, a small sequencer
// and one shared month-subtract step. Depends on cda_pkg.
//
// Holds a day, month and year and applies one transaction at a time: load a
// date, step one day, or add up to 4095 days. Every input transaction gives
// exactly one output transaction with the resulting date; in_tready is low
// from acceptance until that result is taken. Load refreshes the leap-year
// flag before the result; increment goes straight to the result, or
// refreshes the leap flag first when the year rolls over. Add days sets up
// the sum, then the shared subtract-and-advance step walks one month at a
// time, with a leap flag refresh through the divide-by-100 multiplier at
// each year boundary crossed, and then the result is presented.
module calendar_date_advance (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [4:0] load_day, [8:5] load_month, [22:9] load_year,
  // [34:23] days_to_add, [39:35] zero
  input  logic [39:0] in_tdata,
  // [1:0] operation
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [4:0] out_day, [8:5] out_month, [22:9] out_year, [23] zero
  output logic [23:0] out_tdata
);

  cda_pkg::state_t state_r, state_nxt;
  logic [cda_pkg::DACC_W-1:0]  day_r, day_nxt;
  logic [cda_pkg::MONTH_W-1:0] month_r, month_nxt;
  logic [cda_pkg::YEAR_W-1:0]  year_r, year_nxt;
  logic                        leap_r, leap_nxt;
  logic                        adding_r, adding_nxt;

  logic [cda_pkg::DAY_W-1:0]   len;
  logic [cda_pkg::MONTH_W-1:0] mon_adv;
  logic [cda_pkg::YEAR_W-1:0]  year_adv;
  logic                        year_wrap;
  logic [cda_pkg::ADDF_W-1:0]  add_val;
  cda_pkg::op_t                op;

  assign op      = cda_pkg::op_t'(in_tuser);
  assign add_val = in_tdata[34:23] & cda_pkg::ADD_MASK;
  assign len     = cda_pkg::month_len(month_r, leap_r);

  // Month step shared by increment and add.
  always_comb begin
    year_wrap = (month_r >= cda_pkg::MONTH_LAST);
    if (year_wrap) begin
      mon_adv  = cda_pkg::MONTH_W'(1);
      year_adv = (year_r >= cda_pkg::YEAR_LAST) ? '0 : year_r + 1'b1;
    end else begin
      mon_adv  = month_r + 1'b1;
      year_adv = year_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= cda_pkg::ST_IDLE;
      day_r    <= cda_pkg::DACC_W'(1);
      month_r  <= cda_pkg::MONTH_W'(1);
      year_r   <= '0;
      leap_r   <= 1'b1;
      adding_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      day_r    <= day_nxt;
      month_r  <= month_nxt;
      year_r   <= year_nxt;
      leap_r   <= leap_nxt;
      adding_r <= adding_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    day_nxt    = day_r;
    month_nxt  = month_r;
    year_nxt   = year_r;
    leap_nxt   = leap_r;
    adding_nxt = adding_r;
    unique case (state_r)
      cda_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          unique case (op)
            cda_pkg::OP_LOAD: begin
              day_nxt    = cda_pkg::DACC_W'(in_tdata[4:0]);
              month_nxt  = in_tdata[8:5];
              year_nxt   = in_tdata[22:9];
              adding_nxt = 1'b0;
              state_nxt  = cda_pkg::ST_LEAP;
            end
            cda_pkg::OP_INC: begin
              if (day_r >= cda_pkg::DACC_W'(len)) begin
                day_nxt   = cda_pkg::DACC_W'(1);
                month_nxt = mon_adv;
                year_nxt  = year_adv;
                adding_nxt = 1'b0;
                state_nxt = year_wrap ? cda_pkg::ST_LEAP : cda_pkg::ST_OUT;
              end else begin
                day_nxt   = day_r + 1'b1;
                state_nxt = cda_pkg::ST_OUT;
              end
            end
            cda_pkg::OP_ADD: begin
              day_nxt    = day_r + cda_pkg::DACC_W'(add_val);
              adding_nxt = 1'b1;
              state_nxt  = cda_pkg::ST_LOOP;
            end
            default: state_nxt = cda_pkg::ST_OUT;
          endcase
        end
      end
      cda_pkg::ST_LOOP: begin
        // Take a month per cycle, pausing at year ends, until the day fits.
        if (day_r > cda_pkg::DACC_W'(len)) begin
          day_nxt   = day_r - cda_pkg::DACC_W'(len);
          month_nxt = mon_adv;
          year_nxt  = year_adv;
          if (year_wrap) begin
            state_nxt = cda_pkg::ST_LEAP;
          end
        end else begin
          state_nxt = cda_pkg::ST_OUT;
        end
      end
      cda_pkg::ST_LEAP: begin
        leap_nxt  = cda_pkg::is_leap(year_r);
        state_nxt = adding_r ? cda_pkg::ST_LOOP : cda_pkg::ST_OUT;
      end
      cda_pkg::ST_OUT: begin
        if (out_tready) begin
          state_nxt = cda_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cda_pkg::ST_IDLE;
    endcase
  end

  assign in_tready  = (state_r == cda_pkg::ST_IDLE);
  assign out_tvalid = (state_r == cda_pkg::ST_OUT);
  assign out_tdata  = {1'b0, year_r, month_r, day_r[cda_pkg::DAY_W-1:0]};

endmodule

// ===== verif/testbench.sv =====
// Testbench for calendar_date_advance: drives load, increment and add-days
// transactions and checks every returned date against a date predictor.
// Depends on cda_pkg and calendar_date_advance.
`timescale 1ns / 100ps

module testbench;

  localparam logic [1:0] OP_NONE = 2'd3;  // unused code: date held and returned
  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 160;

  typedef struct packed {
    logic [cda_pkg::DAY_W-1:0]   day;
    logic [cda_pkg::MONTH_W-1:0] month;
    logic [cda_pkg::YEAR_W-1:0]  year;
  } date_t;

  class date_scoreboard;
    logic [cda_pkg::DACC_W-1:0]  day_q;
    logic [cda_pkg::MONTH_W-1:0] month_q;
    logic [cda_pkg::YEAR_W-1:0]  year_q;
    date_t                       pending_dates[$];
    int                          errors;

    function new();
      day_q   = cda_pkg::DACC_W'(1);
      month_q = cda_pkg::MONTH_W'(1);
      year_q  = '0;
      errors  = 0;
    endfunction

    function bit leap_year(logic [cda_pkg::YEAR_W-1:0] y);
      int yi;
      yi = int'(y);
      return (yi % 400 == 0) || ((yi % 4 == 0) && (yi % 100 != 0));
    endfunction

    function int days_in_month(logic [cda_pkg::MONTH_W-1:0] m,
                               logic [cda_pkg::YEAR_W-1:0] y);
      unique case (m)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 31;
        4'd4, 4'd6, 4'd9, 4'd11:                    return 30;
        default:                                    return leap_year(y) ? 29 : 28;
      endcase
    endfunction

    function void roll_month();
      if (month_q >= cda_pkg::MONTH_LAST) begin
        month_q = cda_pkg::MONTH_W'(1);
        year_q  = (year_q >= cda_pkg::YEAR_LAST) ? '0 : year_q + 1'b1;
      end else begin
        month_q = month_q + 1'b1;
      end
    endfunction

    // Advance the date by one accepted input transaction and queue the result.
    function void note_input(logic [1:0] op, logic [39:0] data);
      int total;
      int len;
      date_t res;
      if (op == cda_pkg::OP_LOAD) begin
        day_q   = cda_pkg::DACC_W'(data[4:0]);
        month_q = data[8:5];
        year_q  = data[22:9];
      end else if (op == cda_pkg::OP_INC) begin
        if (int'(day_q) >= days_in_month(month_q, year_q)) begin
          day_q = cda_pkg::DACC_W'(1);
          roll_month();
        end else begin
          day_q = day_q + 1'b1;
        end
      end else if (op == cda_pkg::OP_ADD) begin
        total = int'(day_q) + int'(data[34:23] & cda_pkg::ADD_MASK);
        len   = days_in_month(month_q, year_q);
        while (total > len) begin
          total = total - len;
          roll_month();
          len = days_in_month(month_q, year_q);
        end
        day_q = cda_pkg::DACC_W'(total);
      end
      res.day   = day_q[cda_pkg::DAY_W-1:0];
      res.month = month_q;
      res.year  = year_q;
      pending_dates.push_back(res);
    endfunction

    function void check_output(logic [23:0] data);
      date_t want;
      if (pending_dates.size() == 0) begin
        $error("result %h with no date expected", data);
        errors++;
        return;
      end
      want = pending_dates.pop_front();
      if (data[4:0] !== want.day) begin
        $error("out_day mismatch: expected %0d, actual %0d", want.day, data[4:0]);
        errors++;
      end
      if (data[8:5] !== want.month) begin
        $error("out_month mismatch: expected %0d, actual %0d", want.month, data[8:5]);
        errors++;
      end
      if (data[22:9] !== want.year) begin
        $error("out_year mismatch: expected %0d, actual %0d", want.year, data[22:9]);
        errors++;
      end
      if (data[23] !== 1'b0) begin
        $error("out_tdata pad mismatch: expected 0, actual %b", data[23]);
        errors++;
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  date_scoreboard sb = new();
  bit hold_off_request = 1'b0;
  bit steady_run       = 1'b0;
  int idle_cycles      = 0;

  calendar_date_advance uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_input(in_tuser, in_tdata);
      if (out_tvalid && out_tready) sb.check_output(out_tdata);
    end
  end

  // Watchdog: count cycles with no transaction on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Result side: random ready runs, mostly short, a long hold on request, and steady ready in steady_run.
  initial begin
    int run;
    forever begin
      @(posedge clk);
      if (hold_off_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_request = 1'b0;
      end else if (steady_run) begin
        out_tready <= 1'b1;
      end else begin
        run = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 4) : $urandom_range(10, 40);
        out_tready <= ($urandom_range(0, 99) < 70);
        repeat (run - 1) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [4:0] d,
                           input logic [3:0] m, input logic [13:0] y,
                           input logic [11:0] n);
    int gap;
    if (steady_run) gap = 0;
    else if ($urandom_range(0, 99) < 60) gap = 0;
    else if ($urandom_range(0, 99) < 75) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tuser  <= op;
    in_tdata  <= {5'b0, n, y, m, d};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_random_item();
    logic [1:0]  op;
    logic [4:0]  d;
    logic [3:0]  m;
    logic [13:0] y;
    logic [11:0] n;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 22) op = cda_pkg::OP_LOAD;
    else if (pick < 58) op = cda_pkg::OP_INC;
    else if (pick < 95) op = cda_pkg::OP_ADD;
    else op = OP_NONE;

    pick = $urandom_range(0, 99);
    if (pick < 10) d = 5'($urandom);
    else if (pick < 40) d = 5'($urandom_range(27, 31));
    else d = 5'($urandom_range(1, 28));
    m = ($urandom_range(0, 99) < 90) ? 4'($urandom_range(1, 12)) : 4'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 50) y = 14'($urandom_range(0, 9999));
    else if (pick < 65) y = 14'($urandom_range(9985, 9999));
    else if (pick < 85) y = 14'(100 * $urandom_range(0, 99));
    else y = 14'($urandom);

    pick = $urandom_range(0, 99);
    if (pick < 55) n = 12'($urandom_range(0, 40));
    else if (pick < 88) n = 12'($urandom_range(0, 400));
    else n = 12'($urandom);
    send_item(op, d, m, y, n);
  endtask

  // Step past the accepting edge first so the last transaction is queued.
  task automatic wait_for_drain();
    @(posedge clk);
    while (sb.pending_dates.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset date, rollovers, leap rules, odd loaded values.
    send_item(cda_pkg::OP_INC,  5'd0,  4'd0,  14'd0,     12'd0);
    send_item(cda_pkg::OP_LOAD, 5'd31, 4'd12, 14'd9999,  12'd0);
    send_item(cda_pkg::OP_INC,  5'd0,  4'd0,  14'd0,     12'd0);
    send_item(cda_pkg::OP_LOAD, 5'd28, 4'd2,  14'd1900,  12'd0);
    send_item(cda_pkg::OP_INC,  5'd0,  4'd0,  14'd0,     12'd0);
    send_item(cda_pkg::OP_LOAD, 5'd28, 4'd2,  14'd2000,  12'd0);
    send_item(cda_pkg::OP_INC,  5'd0,  4'd0,  14'd0,     12'd0);
    send_item(cda_pkg::OP_INC,  5'd0,  4'd0,  14'd0,     12'd0);
    send_item(cda_pkg::OP_LOAD, 5'd0,  4'd5,  14'd2023,  12'd0);
    send_item(cda_pkg::OP_INC,  5'd0,  4'd0,  14'd0,     12'd0);
    send_item(cda_pkg::OP_LOAD, 5'd0,  4'd6,  14'd100,   12'd0);
    send_item(cda_pkg::OP_ADD,  5'd0,  4'd0,  14'd0,     12'd0);
    send_item(cda_pkg::OP_LOAD, 5'd31, 4'd4,  14'd2001,  12'd0);
    send_item(cda_pkg::OP_INC,  5'd0,  4'd0,  14'd0,     12'd0);
    send_item(cda_pkg::OP_LOAD, 5'd31, 4'd0,  14'd2000,  12'd0);
    send_item(cda_pkg::OP_INC,  5'd0,  4'd0,  14'd0,     12'd0);
    send_item(cda_pkg::OP_LOAD, 5'd31, 4'd15, 14'd16383, 12'd0);
    send_item(cda_pkg::OP_ADD,  5'd0,  4'd0,  14'd0,     12'd4095);
    send_item(cda_pkg::OP_LOAD, 5'd5,  4'd13, 14'd12000, 12'd0);
    send_item(cda_pkg::OP_INC,  5'd0,  4'd0,  14'd0,     12'd0);
    send_item(cda_pkg::OP_LOAD, 5'd31, 4'd12, 14'd9999,  12'd0);
    send_item(cda_pkg::OP_ADD,  5'd0,  4'd0,  14'd0,     12'd4095);
    send_item(OP_NONE,          5'd31, 4'd15, 14'd16383, 12'd4095);
    send_item(cda_pkg::OP_LOAD, 5'd0,  4'd0,  14'd0,     12'd0);
    send_item(cda_pkg::OP_ADD,  5'd0,  4'd0,  14'd0,     12'd1234);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 100) hold_off_request = 1'b1;
      if (i == 200) wait_for_drain();
      if (i == 250) steady_run = 1'b1;
      if (i == 300) steady_run = 1'b0;
      send_random_item();
    end
    in_tvalid <= 1'b0;

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_dates.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
